/* src/tpba_pkg.sv */
// shared types and constants for the two-pool bump allocator
// no dependencies; imported by tpba_table and two_pool_bump_allocator

package tpba_pkg;

  localparam int OFFSET_W   = 25;
  localparam int REQ_W      = 24;
  localparam int CFG_ENT_W  = 9;
  localparam int HANDLE_W   = 32;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam logic [31:0] POOL_BYTES_MAX = 32'd16777216;

  localparam int POOL_GENERAL = 0;
  localparam int POOL_CHIP    = 1;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_LAST   = 3'd3,
    ST_BAD_INDEX  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHIP_BYTES     = 3'd0,
    CFG_GENERAL_BYTES  = 3'd1,
    CFG_CHIP_ENTRIES   = 3'd2,
    CFG_GENERAL_ENTRIES = 3'd3,
    CFG_CHIP_BASE      = 3'd4,
    CFG_GENERAL_BASE   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] size;
  } entry_t;

endpackage

/* src/tpba_table.sv */
// handle table memory of one pool: one write port, one registered read port
// depends on tpba_pkg for the entry type

module tpba_table #(
  parameter int TABLE_DEPTH = tpba_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr_i,
  input  tpba_pkg::entry_t               wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] raddr_i,
  output tpba_pkg::entry_t               rdata_o
);
  import tpba_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/two_pool_bump_allocator.sv */
// two-pool bump allocator top level: config registers, request stage, result register
// depends on tpba_pkg and tpba_table

// Two bump pools (general and chip), each with a next-free offset, an entry
// count and a handle table of block offset and size. A request is taken
// every cycle when the result side keeps up. Each request is registered
// in the request stage together with its handle-table read from the
// table's registered read port. When the request stage advances, the
// request is evaluated against the pool state, offset, count and table
// are updated, and the result is loaded into the result register.
// A table write from one request that hits the entry read by the very next
// request is forwarded from a small write-tracking register. A stalled
// result holds the request stage, and the request stage then stalls its
// input. Allocate rounds odd sizes up to even, checks pool capacity before
// table capacity and returns a handle whose bit 31 marks the chip pool.
// Free only rolls back the most recent block of the pool named by the
// handle. Any error status returns zero handle, address and size and leaves
// the state alone. Configuration writes are expected only while idle.

module two_pool_bump_allocator #(
  parameter int TABLE_DEPTH = tpba_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tpba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tpba_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          func_i,
  input  logic                                pool_select_i,
  input  logic [tpba_pkg::REQ_W-1:0]          request_bytes_i,
  input  logic [tpba_pkg::HANDLE_W-1:0]       handle_in_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tpba_pkg::HANDLE_W-1:0]       handle_out_o,
  output logic [tpba_pkg::ADDR_W-1:0]         mem_addr_o,
  output logic [tpba_pkg::OFFSET_W-1:0]       block_bytes_o,
  output logic [2:0]                          status_o
);
  import tpba_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int TCMP_W = (CNT_W > CFG_ENT_W) ? CNT_W : CFG_ENT_W;
  localparam logic [TCMP_W-1:0] DEPTH_C = TCMP_W'(TABLE_DEPTH);

  // configuration registers, indexed by pool (0 general, 1 chip)
  logic [OFFSET_W-1:0]  pool_bytes_q [2];
  logic [CFG_ENT_W-1:0] table_entries_q [2];
  logic [ADDR_W-1:0]    pool_base_q [2];

  // pool state
  logic [OFFSET_W-1:0] next_off_q [2];
  logic [CNT_W-1:0]    count_q [2];

  // request stage
  logic                s1_valid_q;
  func_e               s1_func_q;
  logic                s1_pool_q;
  logic [REQ_W-1:0]    s1_bytes_q;
  logic [HANDLE_W-1:0] s1_handle_q;

  // last table write, forwarded to the next request
  logic             wr_valid_q;
  logic             wr_pool_q;
  logic [IDX_W-1:0] wr_addr_q;
  entry_t           wr_entry_q;

  // result register
  logic                out_valid_q;
  logic [HANDLE_W-1:0] res_handle_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic [OFFSET_W-1:0] res_bytes_q;
  status_e             res_status_q;

  logic advance;
  logic accept;

  // pipeline moves when the result register is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_bytes_q[POOL_GENERAL]    <= '0;
      pool_bytes_q[POOL_CHIP]       <= '0;
      table_entries_q[POOL_GENERAL] <= '0;
      table_entries_q[POOL_CHIP]    <= '0;
      pool_base_q[POOL_GENERAL]     <= '0;
      pool_base_q[POOL_CHIP]        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHIP_BYTES:      pool_bytes_q[POOL_CHIP]       <= cfg_data_i[OFFSET_W-1:0];
        CFG_GENERAL_BYTES:   pool_bytes_q[POOL_GENERAL]    <= cfg_data_i[OFFSET_W-1:0];
        CFG_CHIP_ENTRIES:    table_entries_q[POOL_CHIP]    <= cfg_data_i[CFG_ENT_W-1:0];
        CFG_GENERAL_ENTRIES: table_entries_q[POOL_GENERAL] <= cfg_data_i[CFG_ENT_W-1:0];
        CFG_CHIP_BASE:       pool_base_q[POOL_CHIP]        <= cfg_data_i[ADDR_W-1:0];
        CFG_GENERAL_BASE:    pool_base_q[POOL_GENERAL]     <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handle tables, read on accept at the handle index of the request
  // ---------------------------------------------------------------------
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  entry_t           tbl_wdata;
  entry_t           tbl_rdata [2];
  logic             sel;

  for (genvar g = 0; g < 2; g++) begin : g_table
    tpba_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
      .clk_i  (clk_i),
      .we_i   (tbl_we && (sel == 1'(g))),
      .waddr_i(tbl_waddr),
      .wdata_i(tbl_wdata),
      .re_i   (accept),
      .raddr_i(handle_in_i[IDX_W-1:0]),
      .rdata_o(tbl_rdata[g])
    );
  end

  // ---------------------------------------------------------------------
  // request stage register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q   <= func_e'(func_i);
      s1_pool_q   <= pool_select_i;
      s1_bytes_q  <= request_bytes_i;
      s1_handle_q <= handle_in_i;
    end
  end

  // ---------------------------------------------------------------------
  // request evaluation
  // ---------------------------------------------------------------------
  logic [OFFSET_W-1:0] size_even;
  logic [31:0]         cap;
  logic [31:0]         end_off;
  logic [TCMP_W-1:0]   tcap;
  logic [OFFSET_W-1:0] cur_off;
  logic [CNT_W-1:0]    cur_cnt;
  logic [30:0]         idx;
  logic                idx_ok;
  logic                idx_last;
  entry_t              entry;

  logic                upd;
  logic [OFFSET_W-1:0] upd_off;
  logic [CNT_W-1:0]    upd_cnt;
  logic [HANDLE_W-1:0] res_handle;
  logic [ADDR_W-1:0]   res_addr;
  logic [OFFSET_W-1:0] res_bytes;
  status_e             res_status;

  always_comb begin
    sel       = (s1_func_q == FUNC_ALLOC) ? s1_pool_q : s1_handle_q[HANDLE_W-1];
    cur_off   = next_off_q[sel];
    cur_cnt   = count_q[sel];

    // odd sizes round up to even
    size_even = {1'b0, s1_bytes_q} + OFFSET_W'(s1_bytes_q[0]);
    cap       = ({7'd0, pool_bytes_q[sel]} > POOL_BYTES_MAX) ? POOL_BYTES_MAX
                                                              : {7'd0, pool_bytes_q[sel]};
    end_off   = 32'(cur_off) + 32'(size_even);
    tcap      = (TCMP_W'(table_entries_q[sel]) > DEPTH_C) ? DEPTH_C
                                                          : TCMP_W'(table_entries_q[sel]);

    idx       = s1_handle_q[30:0];
    idx_ok    = idx < 31'(cur_cnt);
    idx_last  = idx == (31'(cur_cnt) - 31'd1);

    // forward the most recent table write when it is to the same entry
    if (wr_valid_q && (wr_pool_q == sel) && (wr_addr_q == idx[IDX_W-1:0])) begin
      entry = wr_entry_q;
    end else begin
      entry = tbl_rdata[sel];
    end

    upd        = 1'b0;
    upd_off    = cur_off;
    upd_cnt    = cur_cnt;
    tbl_we     = 1'b0;
    tbl_waddr  = cur_cnt[IDX_W-1:0];
    tbl_wdata  = '{offset: cur_off, size: size_even};
    res_handle = '0;
    res_addr   = '0;
    res_bytes  = '0;
    res_status = ST_OK;

    case (s1_func_q)
      FUNC_ALLOC: begin
        if (end_off > cap) begin
          res_status = ST_EXHAUSTED;
        end else if (TCMP_W'(cur_cnt) >= tcap) begin
          res_status = ST_TABLE_FULL;
        end else begin
          tbl_we     = s1_valid_q && advance;
          upd        = 1'b1;
          upd_off    = end_off[OFFSET_W-1:0];
          upd_cnt    = cur_cnt + CNT_W'(1);
          res_handle = {sel, 31'(cur_cnt)};
          res_addr   = pool_base_q[sel] + 32'(cur_off);
          res_bytes  = size_even;
        end
      end
      FUNC_FREE, FUNC_LOOKUP: begin
        if (!idx_ok) begin
          res_status = ST_BAD_INDEX;
        end else if ((s1_func_q == FUNC_FREE) && !idx_last) begin
          res_status = ST_NOT_LAST;
        end else begin
          res_handle = s1_handle_q;
          res_addr   = pool_base_q[sel] + 32'(entry.offset);
          res_bytes  = entry.size;
          if (s1_func_q == FUNC_FREE) begin
            // roll back the most recent block of this pool
            upd     = 1'b1;
            upd_off = entry.offset;
            upd_cnt = idx[CNT_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // pool state and write tracking
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_off_q[POOL_GENERAL] <= '0;
      next_off_q[POOL_CHIP]    <= '0;
      count_q[POOL_GENERAL]    <= '0;
      count_q[POOL_CHIP]       <= '0;
      wr_valid_q               <= 1'b0;
    end else if (s1_valid_q && advance) begin
      if (upd) begin
        next_off_q[sel] <= upd_off;
        count_q[sel]    <= upd_cnt;
      end
      if (tbl_we) begin
        wr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      wr_pool_q  <= sel;
      wr_addr_q  <= tbl_waddr;
      wr_entry_q <= tbl_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      res_handle_q <= res_handle;
      res_addr_q   <= res_addr;
      res_bytes_q  <= res_bytes;
      res_status_q <= res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign handle_out_o  = res_handle_q;
  assign mem_addr_o    = res_addr_q;
  assign block_bytes_o = res_bytes_q;
  assign status_o      = res_status_q;

endmodule
